// File: hdl/psds_pkg.sv
// Shared constants and types for the polarized dust Stokes source pipeline.
package psds_pkg;

  // Field and datapath widths
  localparam int FIELD_W = 16;
  localparam int COEF_W  = 18;
  localparam int ROW_W   = 54;
  localparam int POL_W   = 16;
  localparam int DUST_W  = 24;
  localparam int OUT_W   = 32;
  localparam int MAG_W   = 26;   // rotated component magnitude, Q.8
  localparam int SQ_W    = 52;   // square of a magnitude
  localparam int DIV_W   = 54;   // divider operand width
  localparam int RAT_W   = 17;   // Q1.16 ratio, 0..65536
  localparam int JQ_W    = 33;   // rounded emission, Q16.16
  localparam int DIV_STEPS = 17; // quotient bits, one per stage

  // Configuration register indexes
  localparam logic [1:0] CFG_ROW_ZERO = 2'd0;
  localparam logic [1:0] CFG_ROW_ONE  = 2'd1;
  localparam logic [1:0] CFG_ROW_TWO  = 2'd2;
  localparam logic [1:0] CFG_POL_MAX  = 2'd3;

  // Reset values: identity matrix, P = 0.15
  localparam logic [ROW_W-1:0] ROW_ZERO_RST = 54'd65536;
  localparam logic [ROW_W-1:0] ROW_ONE_RST  = 54'd17179869184;
  localparam logic [ROW_W-1:0] ROW_TWO_RST  = 54'd4503599627370496;
  localparam logic [POL_W-1:0] POL_MAX_RST  = 16'd9830;

  // Q0.16 two thirds
  localparam logic signed [COEF_W-1:0] TWO_THIRDS_Q16 = 18'sd43691;

  // Per-beat sideband that travels alongside the dividers
  typedef struct packed {
    logic              zero;   // projected field is zero
    logic              n1;     // cos2phi numerator negative
    logic              n2;     // sin2phi numerator negative
    logic [JQ_W-1:0]   jq;     // rounded emission
    logic [DUST_W-1:0] kap;    // opacity pass-through
  } psds_side_t;

endpackage

// File: hdl/psds_div.sv
// Pipelined restoring divider giving a rounded Q1.16 ratio of num/den.
module psds_div #(
  parameter int W  = 54,
  parameter int QB = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  output logic [QB-1:0] quo
);

  logic [W-1:0]  r_r   [QB];
  logic [W-1:0]  d_r   [QB];
  logic [QB-1:0] q_r   [QB];
  logic          one_r [QB];

  // One quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [W:0]    rs;
    logic [W-1:0]  dk;
    logic [QB-1:0] qk;
    logic          ok;

    if (k == 0) begin : g_first
      assign rs = {num, 1'b0};
      assign dk = den;
      assign qk = '0;
      assign ok = (num >= den);
    end else begin : g_next
      assign rs = {r_r[k-1], 1'b0};
      assign dk = d_r[k-1];
      assign qk = q_r[k-1];
      assign ok = one_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rs >= {1'b0, dk}) begin
          r_r[k] <= W'(rs - {1'b0, dk});
          q_r[k] <= {qk[QB-2:0], 1'b1};
        end else begin
          r_r[k] <= rs[W-1:0];
          q_r[k] <= {qk[QB-2:0], 1'b0};
        end
        d_r[k]   <= dk;
        one_r[k] <= ok;
      end
    end
  end

  // Round the extra bit away; num >= den saturates to one
  logic [QB:0] q_inc;
  assign q_inc = {1'b0, q_r[QB-1]} + (QB+1)'(1);
  assign quo   = one_r[QB-1] ? (QB'(1) << (QB-1)) : q_inc[QB:1];

endmodule

// File: hdl/psds_front.sv
// Front stages: field rotation, cut to Q.8, squares and divider operands.
module psds_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic signed [15:0]            field_x,
  input  logic signed [15:0]            field_y,
  input  logic signed [15:0]            field_z,
  input  logic [psds_pkg::DUST_W-1:0]   dust,
  input  logic [psds_pkg::DUST_W-1:0]   kap,
  input  logic [psds_pkg::ROW_W-1:0]    row0,
  input  logic [psds_pkg::ROW_W-1:0]    row1,
  input  logic [psds_pkg::ROW_W-1:0]    row2,
  output logic                          vld_o,
  output logic [psds_pkg::DIV_W-1:0]    num_c,
  output logic [psds_pkg::DIV_W-1:0]    den_c,
  output logic [psds_pkg::DIV_W-1:0]    num_t1,
  output logic [psds_pkg::DIV_W-1:0]    num_t2,
  output logic [psds_pkg::DIV_W-1:0]    den_xy,
  output psds_pkg::psds_side_t          side_o
);

  logic signed [15:0]               b    [3];
  logic [psds_pkg::ROW_W-1:0]       row  [3];

  assign b[0] = field_x;
  assign b[1] = field_y;
  assign b[2] = field_z;
  assign row[0] = row0;
  assign row[1] = row1;
  assign row[2] = row2;

  // Stage 1: nine coefficient products and the emission product
  logic signed [33:0]               prod_r [3][3];
  logic [47:0]                      j32_r;
  logic [psds_pkg::DUST_W-1:0]      kap1_r;
  logic                             v1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= b[j] * $signed(row[j][18*i +: 18]);
        end
      end
      j32_r  <= dust * kap;
      kap1_r <= kap;
    end
  end

  // Stage 2: sum per component, cut magnitude to 8 fraction bits
  logic signed [35:0]               acc  [3];
  logic [35:0]                      mag  [3];
  logic [psds_pkg::MAG_W-1:0]       ax_r [3];
  logic                             neg_r [3];
  logic [48:0]                      jrnd;
  logic [psds_pkg::JQ_W-1:0]        jq2_r;
  logic [psds_pkg::DUST_W-1:0]      kap2_r;
  logic                             v2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 36'(prod_r[i][0]) + 36'(prod_r[i][1]) + 36'(prod_r[i][2]);
      mag[i] = acc[i][35] ? 36'(-acc[i]) : 36'(acc[i]);
    end
    jrnd = {1'b0, j32_r} + 49'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ax_r[i]  <= mag[i][33:8];
        neg_r[i] <= acc[i][35] && (mag[i][33:8] != '0);
      end
      jq2_r  <= jrnd[48:16];
      kap2_r <= kap1_r;
    end
  end

  // Stage 3: squares and cross product
  logic [psds_pkg::SQ_W-1:0]        xx_r, yy_r, zz_r, xy_r;
  logic                             sx_r, sy_r;
  logic [psds_pkg::JQ_W-1:0]        jq3_r;
  logic [psds_pkg::DUST_W-1:0]      kap3_r;
  logic                             v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r   <= ax_r[0] * ax_r[0];
      yy_r   <= ax_r[1] * ax_r[1];
      zz_r   <= ax_r[2] * ax_r[2];
      xy_r   <= ax_r[0] * ax_r[1];
      sx_r   <= neg_r[0];
      sy_r   <= neg_r[1];
      jq3_r  <= jq2_r;
      kap3_r <= kap2_r;
    end
  end

  // Stage 4: divider operands and sign flags
  logic [psds_pkg::SQ_W:0]          sxy;
  logic [psds_pkg::DIV_W-1:0]       num_c_r, den_c_r, num_t1_r, num_t2_r, den_xy_r;
  psds_pkg::psds_side_t             side_r;
  logic                             v4_r;

  assign sxy = {1'b0, xx_r} + {1'b0, yy_r};

  always_ff @(posedge clk) begin
    if (en) begin
      num_c_r  <= psds_pkg::DIV_W'(sxy);
      den_c_r  <= psds_pkg::DIV_W'(sxy) + psds_pkg::DIV_W'(zz_r);
      den_xy_r <= psds_pkg::DIV_W'(sxy);
      num_t2_r <= psds_pkg::DIV_W'({xy_r, 1'b0});
      if (xx_r >= yy_r) begin
        num_t1_r  <= psds_pkg::DIV_W'(xx_r - yy_r);
        side_r.n1 <= 1'b0;
      end else begin
        num_t1_r  <= psds_pkg::DIV_W'(yy_r - xx_r);
        side_r.n1 <= 1'b1;
      end
      side_r.n2   <= (sx_r != sy_r);
      side_r.zero <= (sxy == '0);
      side_r.jq   <= jq3_r;
      side_r.kap  <= kap3_r;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign vld_o  = v4_r;
  assign num_c  = num_c_r;
  assign den_c  = den_c_r;
  assign num_t1 = num_t1_r;
  assign num_t2 = num_t2_r;
  assign den_xy = den_xy_r;
  assign side_o = side_r;

endmodule

// File: hdl/psds_back.sv
// Back stages: angle products, Stokes scaling, saturation and output register.
module psds_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  psds_pkg::psds_side_t          side_i,
  input  logic [psds_pkg::RAT_W-1:0]    c_i,
  input  logic [psds_pkg::RAT_W-1:0]    t1_i,
  input  logic [psds_pkg::RAT_W-1:0]    t2_i,
  input  logic [psds_pkg::POL_W-1:0]    pol,
  output logic                          out_valid,
  output logic [31:0]                   stokes_i,
  output logic [31:0]                   stokes_q,
  output logic [31:0]                   stokes_u,
  output logic [psds_pkg::DUST_W-1:0]   absorption,
  output logic                          saturated
);

  // Stage 1: zero case, sign cleanup, P*(c-2/3) and P*c
  logic [psds_pkg::RAT_W-1:0]       c, t1, t2;
  logic signed [17:0]               d;
  logic [33:0]                      pc;
  logic signed [34:0]               pd1_r;
  logic [psds_pkg::RAT_W-1:0]       g1_r, t11_r, t21_r;
  logic                             n11_r, n21_r, z1_r, v1_r;
  logic [psds_pkg::JQ_W-1:0]        jq1_r;
  logic [psds_pkg::DUST_W-1:0]      kap1_r;

  always_comb begin
    c  = side_i.zero ? '0 : c_i;
    t1 = side_i.zero ? '0 : t1_i;
    t2 = side_i.zero ? '0 : t2_i;
    d  = $signed({1'b0, c}) - psds_pkg::TWO_THIRDS_Q16;
    pc = 34'(pol * c) + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd1_r  <= $signed({1'b0, pol}) * d;
      g1_r   <= pc[32:16];
      t11_r  <= t1;
      t21_r  <= t2;
      n11_r  <= side_i.n1 && (t1 != '0);
      n21_r  <= side_i.n2 && (t2 != '0);
      z1_r   <= side_i.zero;
      jq1_r  <= side_i.jq;
      kap1_r <= side_i.kap;
    end
  end

  // Stage 2: intensity factor and polarized fractions
  logic signed [35:0]               f32;
  logic [34:0]                      h1s, h2s;
  logic [psds_pkg::RAT_W-1:0]       f2_r, h12_r, h22_r;
  logic                             n12_r, n22_r, z2_r, v2_r;
  logic [psds_pkg::JQ_W-1:0]        jq2_r;
  logic [psds_pkg::DUST_W-1:0]      kap2_r;

  always_comb begin
    f32 = 36'sd4294967296 - 36'(pd1_r) + 36'sd32768;
    h1s = 35'(g1_r * t11_r) + 35'd32768;
    h2s = 35'(g1_r * t21_r) + 35'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r   <= f32[32:16];
      h12_r  <= h1s[32:16];
      h22_r  <= h2s[32:16];
      n12_r  <= n11_r;
      n22_r  <= n21_r;
      z2_r   <= z1_r;
      jq2_r  <= jq1_r;
      kap2_r <= kap1_r;
    end
  end

  // Stage 3: scale by emission
  logic [50:0]                      si_s, m1_s, m2_s;
  logic [34:0]                      si3_r, m13_r, m23_r;
  logic                             n13_r, n23_r, z3_r, v3_r;
  logic [psds_pkg::DUST_W-1:0]      kap3_r;

  always_comb begin
    si_s = 51'(jq2_r * f2_r) + 51'd32768;
    m1_s = 51'(jq2_r * h12_r) + 51'd32768;
    m2_s = 51'(jq2_r * h22_r) + 51'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      si3_r  <= si_s[50:16];
      m13_r  <= m1_s[50:16];
      m23_r  <= m2_s[50:16];
      n13_r  <= n12_r;
      n23_r  <= n22_r;
      z3_r   <= z2_r;
      kap3_r <= kap2_r;
    end
  end

  // Saturate and sign
  logic        sat_i, sat_q, sat_u;
  logic [31:0] lim_q, lim_u, mq, mu;

  always_comb begin
    sat_i = (si3_r[34:32] != '0);
    lim_q = n13_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    lim_u = n23_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat_q = (m13_r > {3'b000, lim_q});
    sat_u = (m23_r > {3'b000, lim_u});
    mq    = sat_q ? lim_q : m13_r[31:0];
    mu    = sat_u ? lim_u : m23_r[31:0];
  end

  // Output register
  logic [31:0]                 si_o_r, sq_o_r, su_o_r;
  logic [psds_pkg::DUST_W-1:0] ab_o_r;
  logic                        sat_o_r, z_o_r, vo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      si_o_r  <= sat_i ? 32'hFFFF_FFFF : si3_r[31:0];
      sq_o_r  <= n13_r ? (32'd0 - mq) : mq;
      su_o_r  <= n23_r ? (32'd0 - mu) : mu;
      ab_o_r  <= kap3_r;
      sat_o_r <= sat_i || sat_q || sat_u;
      z_o_r   <= z3_r;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  assign out_valid  = vo_r;
  assign stokes_i   = si_o_r;
  assign stokes_q   = sq_o_r;
  assign stokes_u   = su_o_r;
  assign absorption = ab_o_r;
  assign saturated  = sat_o_r;

  // Zero projected field carries no polarization
  a_zero_unpolarized: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && z_o_r |-> (sq_o_r == '0) && (su_o_r == '0))
    else $error("polarized output on zero projected field");

  // Saturation flag only with a clamped value on some output
  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && sat_o_r |-> (si_o_r == 32'hFFFF_FFFF) || (sq_o_r == 32'h7FFF_FFFF) ||
      (sq_o_r == 32'h8000_0000) || (su_o_r == 32'h7FFF_FFFF) ||
      (su_o_r == 32'h8000_0000))
    else $error("saturated flag without clamped output");

endmodule

// File: hdl/polarized_dust_stokes_source.sv
// Top level of the polarized dust Stokes source pipeline.
// One beat per clock in and one result per beat out while the output is not
// stalled. The pipeline holds four rotation/square stages, seventeen divider
// stages (one quotient bit each, three dividers side by side for cos^2(gamma),
// cos2phi, sin2phi) and four scaling/saturation stages ending in the output
// register. All stages advance together whenever the output register is empty
// or drained, so a stall at the output holds every beat in place. Configuration
// writes take effect at once and are meant to happen while the pipeline is
// empty.
module polarized_dust_stokes_source (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_field_x,
  input  logic signed [15:0]            in_field_y,
  input  logic signed [15:0]            in_field_z,
  input  logic [23:0]                   in_dust_density,
  input  logic [23:0]                   in_opacity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_stokes_i,
  output logic signed [31:0]            out_stokes_q,
  output logic signed [31:0]            out_stokes_u,
  output logic [23:0]                   out_absorption,
  output logic                          out_saturated,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [53:0]                   cfg_wdata
);

  // Configuration registers
  logic [psds_pkg::ROW_W-1:0] row0_r, row1_r, row2_r;
  logic [psds_pkg::POL_W-1:0] pol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= psds_pkg::ROW_ZERO_RST;
      row1_r <= psds_pkg::ROW_ONE_RST;
      row2_r <= psds_pkg::ROW_TWO_RST;
      pol_r  <= psds_pkg::POL_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        psds_pkg::CFG_ROW_ZERO: row0_r <= cfg_wdata;
        psds_pkg::CFG_ROW_ONE:  row1_r <= cfg_wdata;
        psds_pkg::CFG_ROW_TWO:  row2_r <= cfg_wdata;
        psds_pkg::CFG_POL_MAX:  pol_r  <= cfg_wdata[psds_pkg::POL_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: output register empty or being taken
  logic en;
  logic out_valid_w;
  assign en        = !out_valid_w || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_w;

  // Front stages
  logic                       fv;
  logic [psds_pkg::DIV_W-1:0] num_c, den_c, num_t1, num_t2, den_xy;
  psds_pkg::psds_side_t       fside;

  psds_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_valid),
    .field_x (in_field_x),
    .field_y (in_field_y),
    .field_z (in_field_z),
    .dust    (in_dust_density),
    .kap     (in_opacity),
    .row0    (row0_r),
    .row1    (row1_r),
    .row2    (row2_r),
    .vld_o   (fv),
    .num_c   (num_c),
    .den_c   (den_c),
    .num_t1  (num_t1),
    .num_t2  (num_t2),
    .den_xy  (den_xy),
    .side_o  (fside)
  );

  // Three ratio dividers
  logic [psds_pkg::RAT_W-1:0] c_q, t1_q, t2_q;

  psds_div #(.W(psds_pkg::DIV_W), .QB(psds_pkg::RAT_W)) u_div_c (
    .clk (clk), .en (en), .num (num_c), .den (den_c), .quo (c_q)
  );

  psds_div #(.W(psds_pkg::DIV_W), .QB(psds_pkg::RAT_W)) u_div_t1 (
    .clk (clk), .en (en), .num (num_t1), .den (den_xy), .quo (t1_q)
  );

  psds_div #(.W(psds_pkg::DIV_W), .QB(psds_pkg::RAT_W)) u_div_t2 (
    .clk (clk), .en (en), .num (num_t2), .den (den_xy), .quo (t2_q)
  );

  // Sideband and valid delay matching the divider depth
  psds_pkg::psds_side_t dl_side_r [psds_pkg::DIV_STEPS];
  logic                 dl_v_r    [psds_pkg::DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_side_r[0] <= fside;
      for (int k = 1; k < psds_pkg::DIV_STEPS; k++) begin
        dl_side_r[k] <= dl_side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < psds_pkg::DIV_STEPS; k++) begin
        dl_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      dl_v_r[0] <= fv;
      for (int k = 1; k < psds_pkg::DIV_STEPS; k++) begin
        dl_v_r[k] <= dl_v_r[k-1];
      end
    end
  end

  // Back stages and output register
  logic [31:0] sq_w, su_w;

  psds_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_i      (dl_v_r[psds_pkg::DIV_STEPS-1]),
    .side_i     (dl_side_r[psds_pkg::DIV_STEPS-1]),
    .c_i        (c_q),
    .t1_i       (t1_q),
    .t2_i       (t2_q),
    .pol        (pol_r),
    .out_valid  (out_valid_w),
    .stokes_i   (out_stokes_i),
    .stokes_q   (sq_w),
    .stokes_u   (su_w),
    .absorption (out_absorption),
    .saturated  (out_saturated)
  );

  assign out_stokes_q = $signed(sq_w);
  assign out_stokes_u = $signed(su_w);

  // A held result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule
